/* rtl/core/drive_thermal_throttle_governor_macros.svh */
// Assertion macros shared by the drive thermal throttle governor RTL.
// Each macro expects signals named clk and rst_n in the including module.
`ifndef DRIVE_THERMAL_THROTTLE_GOVERNOR_MACROS_SVH
`define DRIVE_THERMAL_THROTTLE_GOVERNOR_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define DTTG_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled during reset.
`define DTTG_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* rtl/core/dttg_pkg.sv */
// Types, constants and register codes of the drive thermal throttle governor.
// No dependencies; every other RTL file but the assertion macro header imports this package.
package dttg_pkg;

  localparam int TEMP_W        = 16;
  localparam int LANE_FIELDS   = 5;
  localparam int NUM_DRIVES_DEF = 5;
  localparam int CFG_DATA_W    = 32;
  localparam int CFG_ADDR_W    = 4;
  localparam int STATUS_W      = 2;

  typedef logic signed [TEMP_W-1:0]      temp_t;
  typedef logic        [LANE_FIELDS-1:0] mask_t;

  localparam temp_t VALID_LOW   = -16'sd100;
  localparam temp_t VALID_HIGH  = 16'sd200;
  localparam temp_t TEMP_FLOOR  = -16'sd273;

  localparam temp_t THROTTLE_RST = 16'sd70;
  localparam temp_t RELEASE_RST  = 16'sd60;
  localparam temp_t CRITICAL_RST = 16'sd80;

  typedef enum logic [1:0] {
    REG_THROTTLE = 2'd0,
    REG_RELEASE  = 2'd1,
    REG_CRITICAL = 2'd2
  } reg_idx_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK   = 2'd0,
    ST_WARN = 2'd1,
    ST_CRIT = 2'd2
  } status_t;

  typedef struct packed {
    temp_t throttle_temp;
    temp_t release_temp;
    temp_t critical_temp;
  } cfg_t;

  typedef struct packed {
    logic  throttled;
    logic  critical;
    temp_t peak;
  } lane_stat_t;

  typedef struct packed {
    mask_t                    allowed_mask;
    mask_t                    throttled_mask;
    mask_t                    critical_mask;
    temp_t                    frame_max;
    status_t                  status;
    temp_t [LANE_FIELDS-1:0]  peak;
  } result_t;

endpackage

/* rtl/core/dttg_if.sv */
// Valid/ready channel interfaces for telemetry frames and governor results.
// Depends on dttg_pkg for the temperature type.
interface dttg_in_if;
  import dttg_pkg::*;
  logic  valid;
  logic  ready;
  logic  frame_valid;
  temp_t temp_0;
  temp_t temp_1;
  temp_t temp_2;
  temp_t temp_3;
  temp_t temp_4;

  modport source (output valid, frame_valid, temp_0, temp_1, temp_2, temp_3, temp_4,
                  input ready);
  modport sink (input valid, frame_valid, temp_0, temp_1, temp_2, temp_3, temp_4,
                output ready);
endinterface

interface dttg_out_if;
  import dttg_pkg::*;
  logic                valid;
  logic                ready;
  mask_t               allowed_mask;
  mask_t               throttled_mask;
  mask_t               critical_mask;
  temp_t               frame_max;
  logic [STATUS_W-1:0] status;
  temp_t               peak_0;
  temp_t               peak_1;
  temp_t               peak_2;
  temp_t               peak_3;
  temp_t               peak_4;

  modport source (output valid, allowed_mask, throttled_mask, critical_mask, frame_max,
                  status, peak_0, peak_1, peak_2, peak_3, peak_4,
                  input ready);
  modport sink (input valid, allowed_mask, throttled_mask, critical_mask, frame_max,
                status, peak_0, peak_1, peak_2, peak_3, peak_4,
                output ready);
endinterface

/* rtl/core/dttg_lane.sv */
// One drive lane: peak tracking and throttle/critical hysteresis flags.
// Depends on dttg_pkg and the shared assertion macro header.
`include "drive_thermal_throttle_governor_macros.svh"

module dttg_lane (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   upd,
  input  dttg_pkg::temp_t        temp,
  input  dttg_pkg::cfg_t         cfg,
  output dttg_pkg::lane_stat_t   stat
);
  import dttg_pkg::*;

  lane_stat_t stat_r;
  lane_stat_t stat_nxt;
  logic       in_win;

  assign in_win = (temp > VALID_LOW) && (temp <= VALID_HIGH);

  always_comb begin
    stat_nxt = stat_r;
    if (upd && in_win) begin
      if (temp > stat_r.peak) begin
        stat_nxt.peak = temp;
      end
      // Critical wins over throttle, which wins over release.
      priority if (temp >= cfg.critical_temp) begin
        stat_nxt.critical  = 1'b1;
        stat_nxt.throttled = 1'b1;
      end else if (temp >= cfg.throttle_temp) begin
        stat_nxt.throttled = 1'b1;
      end else if (temp <= cfg.release_temp) begin
        stat_nxt.critical  = 1'b0;
        stat_nxt.throttled = 1'b0;
      end else begin
        stat_nxt.critical  = stat_r.critical;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stat_r <= '{throttled: 1'b0, critical: 1'b0, peak: TEMP_FLOOR};
    end else begin
      stat_r <= stat_nxt;
    end
  end

  // The result reports the state as left by this frame.
  assign stat = stat_nxt;

  `DTTG_ASSERT_IMPL(a_crit_has_thr, stat_r.critical, stat_r.throttled, "critical without throttled")
  `DTTG_ASSERT_NEXT(a_peak_mono, 1'b1, stat_r.peak >= $past(stat_r.peak), "lane peak decreased")
  `DTTG_ASSERT_NEXT(a_drop_holds, upd && !in_win, $stable(stat_r), "dropped reading changed lane")

endmodule

/* rtl/core/dttg_merge.sv */
// Merging stage: frame maximum, lane masks and overall status of one frame.
// Depends on dttg_pkg for the lane status and result types.
module dttg_merge (
  input  dttg_pkg::lane_stat_t lanes [dttg_pkg::LANE_FIELDS],
  input  dttg_pkg::temp_t      temps [dttg_pkg::LANE_FIELDS],
  input  dttg_pkg::temp_t      critical_temp,
  output dttg_pkg::result_t    res
);
  import dttg_pkg::*;

  temp_t fmax;
  mask_t thr;
  mask_t crit;

  always_comb begin
    fmax = TEMP_FLOOR;
    for (int i = 0; i < LANE_FIELDS; i++) begin
      if (temps[i] > fmax) begin
        fmax = temps[i];
      end
    end
  end

  always_comb begin
    thr  = '0;
    crit = '0;
    for (int i = 0; i < LANE_FIELDS; i++) begin
      thr[i]  = lanes[i].throttled;
      crit[i] = lanes[i].critical;
      res.peak[i] = lanes[i].peak;
    end
    res.allowed_mask   = ~thr;
    res.throttled_mask = thr;
    res.critical_mask  = crit;
    res.frame_max      = fmax;
    if (thr == '0) begin
      res.status = ST_OK;
    end else if (fmax >= critical_temp) begin
      res.status = ST_CRIT;
    end else begin
      res.status = ST_WARN;
    end
  end

endmodule

/* rtl/core/dttg_outbuf.sv */
// Two-entry result buffer: an output register backed by a skid register.
// Depends on dttg_pkg and the shared assertion macro header.
`include "drive_thermal_throttle_governor_macros.svh"

module dttg_outbuf (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                push,
  input  dttg_pkg::result_t   res,
  input  logic                out_ready,
  output logic                out_valid,
  output dttg_pkg::result_t   out_data,
  output logic                room
);
  import dttg_pkg::*;

  logic    out_valid_r;
  logic    out_valid_nxt;
  logic    skid_valid_r;
  logic    skid_valid_nxt;
  result_t out_r;
  result_t skid_r;
  logic    pop;
  logic    out_free;

  assign pop      = out_valid_r && out_ready;
  assign out_free = !out_valid_r || pop;

  always_comb begin
    if (out_free) begin
      out_valid_nxt  = skid_valid_r || push;
      skid_valid_nxt = skid_valid_r && push;
    end else begin
      out_valid_nxt  = 1'b1;
      skid_valid_nxt = skid_valid_r || push;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else begin
      out_valid_r  <= out_valid_nxt;
      skid_valid_r <= skid_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (out_free) begin
      out_r <= skid_valid_r ? skid_r : res;
    end
    if (push) begin
      skid_r <= res;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;
  assign room      = !skid_valid_r;

  `DTTG_ASSERT_IMPL(a_skid_behind_out, skid_valid_r, out_valid_r, "skid full with output empty")
  `DTTG_ASSERT_IMPL(a_no_overrun, push, !skid_valid_r, "result pushed into a full buffer")
  `DTTG_ASSERT_NEXT(a_hold_stalled, out_valid_r && !out_ready, out_valid_r, "stalled result lost")

endmodule

/* rtl/core/drive_thermal_throttle_governor.sv */
// Top level of the drive thermal throttle governor: lanes, merge, result buffer.
// Depends on dttg_pkg, dttg_if, dttg_lane, dttg_merge and dttg_outbuf.
//
// Usage:
//   Telemetry frames arrive as beats on in_if (valid/ready). Each beat carries a
//   signature flag and five signed drive temperatures. A beat whose frame_valid
//   is low is taken and dropped: no result and no change of lane state.
//   Each good frame gives one result beat on out_if with the allowed, throttled
//   and critical masks, the frame maximum, the overall status and the lane peaks.
//   Thresholds are written through the APB-style port: throttle_temp at byte
//   address 0, release_temp at 4, critical_temp at 8 (low 16 bits of pwdata).
//   Reads return the thresholds sign-extended to 32 bits; pready is tied high.
// Result path and throughput:
//   A result is registered into the output register when that is free, else
//   into the skid register. One frame per cycle is sustained while the buffer
//   has room; each frame's per-lane compare needs the flags of the one before.
// Reset:
//   rst_n is synchronous and active low. It clears all throttled and critical
//   flags, sets every peak to -273 and loads thresholds 70, 60 and 80.
// Stall:
//   Results sit in a two-entry buffer (output register plus skid register).
//   in_if.ready stays high while the skid register is empty, so one more frame
//   is taken while a finished result waits; it drops only when both are full.
module drive_thermal_throttle_governor #(
  parameter int NUM_DRIVES = dttg_pkg::NUM_DRIVES_DEF
) (
  input  logic                                clk,
  input  logic                                rst_n,
  dttg_in_if.sink                             in_if,
  dttg_out_if.source                          out_if,
  input  logic                                psel,
  input  logic                                penable,
  input  logic                                pwrite,
  input  logic [dttg_pkg::CFG_ADDR_W-1:0]     paddr,
  input  logic [dttg_pkg::CFG_DATA_W-1:0]     pwdata,
  output logic [dttg_pkg::CFG_DATA_W-1:0]     prdata,
  output logic                                pready
);
  import dttg_pkg::*;

  // Lanes with an input field that the configured drive count covers.
  localparam int ACTIVE_LANES = (NUM_DRIVES < LANE_FIELDS) ? NUM_DRIVES : LANE_FIELDS;

  cfg_t       cfg_r;
  cfg_t       cfg_nxt;
  logic       cfg_wr;
  reg_idx_t   cfg_idx;
  temp_t      rd_val;

  logic       in_accept;
  logic       upd;
  logic       room;
  temp_t      temps     [LANE_FIELDS];
  lane_stat_t lane_stat [LANE_FIELDS];
  result_t    res;
  result_t    out_data;

  // Configuration port: a write lands in the access phase.
  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite && pready;
  assign cfg_idx = reg_idx_t'(paddr[CFG_ADDR_W-1:2]);

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_wr) begin
      unique case (cfg_idx)
        REG_THROTTLE: cfg_nxt.throttle_temp = pwdata[TEMP_W-1:0];
        REG_RELEASE:  cfg_nxt.release_temp  = pwdata[TEMP_W-1:0];
        REG_CRITICAL: cfg_nxt.critical_temp = pwdata[TEMP_W-1:0];
        default:      cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= '{throttle_temp: THROTTLE_RST, release_temp: RELEASE_RST,
                 critical_temp: CRITICAL_RST};
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  always_comb begin
    unique case (cfg_idx)
      REG_THROTTLE: rd_val = cfg_r.throttle_temp;
      REG_RELEASE:  rd_val = cfg_r.release_temp;
      REG_CRITICAL: rd_val = cfg_r.critical_temp;
      default:      rd_val = '0;
    endcase
  end

  assign prdata = {{(CFG_DATA_W-TEMP_W){rd_val[TEMP_W-1]}}, rd_val};

  // Input side: a frame is taken whenever the result buffer has a free slot.
  assign in_if.ready = room;
  assign in_accept   = in_if.valid && in_if.ready;
  assign upd         = in_accept && in_if.frame_valid;

  assign temps[0] = in_if.temp_0;
  assign temps[1] = in_if.temp_1;
  assign temps[2] = in_if.temp_2;
  assign temps[3] = in_if.temp_3;
  assign temps[4] = in_if.temp_4;

  // One lane per covered drive; an uncovered lane reports idle with the floor peak,
  // while its raw reading still feeds the frame maximum.
  for (genvar g = 0; g < LANE_FIELDS; g++) begin : g_lane
    if (g < ACTIVE_LANES) begin : g_on
      dttg_lane u_lane (
        .clk   (clk),
        .rst_n (rst_n),
        .upd   (upd),
        .temp  (temps[g]),
        .cfg   (cfg_r),
        .stat  (lane_stat[g])
      );
    end else begin : g_off
      assign lane_stat[g] = '{throttled: 1'b0, critical: 1'b0, peak: TEMP_FLOOR};
    end
  end

  dttg_merge u_merge (
    .lanes         (lane_stat),
    .temps         (temps),
    .critical_temp (cfg_r.critical_temp),
    .res           (res)
  );

  dttg_outbuf u_outbuf (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (upd),
    .res       (res),
    .out_ready (out_if.ready),
    .out_valid (out_if.valid),
    .out_data  (out_data),
    .room      (room)
  );

  assign out_if.allowed_mask   = out_data.allowed_mask;
  assign out_if.throttled_mask = out_data.throttled_mask;
  assign out_if.critical_mask  = out_data.critical_mask;
  assign out_if.frame_max      = out_data.frame_max;
  assign out_if.status         = out_data.status;
  assign out_if.peak_0         = out_data.peak[0];
  assign out_if.peak_1         = out_data.peak[1];
  assign out_if.peak_2         = out_data.peak[2];
  assign out_if.peak_3         = out_data.peak[3];
  assign out_if.peak_4         = out_data.peak[4];

endmodule
